[rtl/qfg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfg_pkg
// Shared types and constants of the quad footprint grid cell scanner.
// ----------------------------------------------------------------------------
package qfg_pkg;

  localparam logic [31:0] CELL_SIZE_RESET = 32'd65536;

  typedef struct packed {
    logic signed [31:0] v0_x;
    logic signed [31:0] v0_y;
    logic signed [31:0] v1_x;
    logic signed [31:0] v1_y;
    logic signed [31:0] v2_x;
    logic signed [31:0] v2_y;
    logic signed [31:0] v3_x;
    logic signed [31:0] v3_y;
  } quad_item_t;

  typedef struct packed {
    logic signed [31:0] cell_x;
    logic signed [31:0] cell_y;
    logic               status;
    logic               last;
  } cell_item_t;

  typedef logic [31:0] cfg_word_t;

  localparam logic STATUS_CELL = 1'b0;
  localparam logic STATUS_OVER = 1'b1;

  typedef struct packed {
    logic done;
    logic pos;
    logic zero;
  } ori_res_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [31:0] rem;
  } div_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BBOX,
    S_DIV,
    S_WIN,
    S_CELL,
    S_VTX,
    S_ORI,
    S_SEG,
    S_XCHK,
    S_XORI,
    S_XDEC,
    S_HIT,
    S_NEXT,
    S_FIN,
    S_OVR
  } state_e;

  // point p within the bounding box of segment a-b
  function automatic logic in_span(
    input logic signed [31:0] ax, input logic signed [31:0] ay,
    input logic signed [31:0] bx, input logic signed [31:0] by,
    input logic signed [31:0] px, input logic signed [31:0] py);
    logic signed [31:0] lx, hx, ly, hy;
    lx = (ax < bx) ? ax : bx;
    hx = (ax < bx) ? bx : ax;
    ly = (ay < by) ? ay : by;
    hy = (ay < by) ? by : ay;
    return (px >= lx) && (px <= hx) && (py >= ly) && (py <= hy);
  endfunction

endpackage

[rtl/qfg_chan_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfg_chan_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface qfg_chan_if #(
  parameter type payload_t = logic [31:0]
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/quad_footprint_grid_cells_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_footprint_grid_cells_core
// Conservative rasterization of a quadrilateral onto a square cell grid.
// ----------------------------------------------------------------------------
// flow: bounding box, floor divisions of the four box bounds and the window check, then per
// window cell a clip test, a vertex test and, if neither settles it, up to 68 orientations
// on the shared multiplier plus edge steps, one result per qualifying cell
// throughput: one item at a time, next item taken once the last result is queued
// reset: cell_size returns to 1.0, scanner idle, no result pending
module quad_footprint_grid_cells_core #(
  parameter int MAX_SCAN_CELLS = 64
) (
  input logic      clk_i,
  input logic      rst_ni,
  qfg_chan_if.sink   cfg_i,
  qfg_chan_if.sink   item_i,
  qfg_chan_if.source result_o
);
  import qfg_pkg::*;

  localparam int CW = $clog2(MAX_SCAN_CELLS + 1);

  state_e state_q, state_d;
  logic [31:0]        size_q;
  logic signed [31:0] vx_q [4];
  logic signed [31:0] vy_q [4];
  logic signed [31:0] bxl_q, bxh_q, byl_q, byh_q;
  logic [1:0]         dix_q;
  logic signed [33:0] fq_q [4];
  logic [31:0]        fr0_q, fr2_q;
  logic signed [33:0] kx_q, ky_q, kx1_q, ky0_q, ky1_q;
  logic signed [35:0] cxb_q, cyb_q, cyb0_q;
  logic signed [31:0] x0_q, y0_q, x1_q, y1_q;
  logic [1:0]         ei_q, k_q, j_q;
  logic [3:0]         opos_q, ozero_q;
  logic               inside_q;
  logic               pend_q;
  logic [31:0]        pend_x_q, pend_y_q;
  logic               ov_q, ost_q, olast_q;
  logic [31:0]        ox_q, oy_q;

  logic in_ready, in_acc, slot_free;
  logic div_go, ori_go, push;
  logic [31:0] push_x, push_y;
  logic push_st, push_last;

  // bounding box
  logic signed [31:0] mnx, mxx, mny, mxy;
  always_comb begin
    mnx = vx_q[0];
    mxx = vx_q[0];
    mny = vy_q[0];
    mxy = vy_q[0];
    for (int i = 1; i < 4; i++) begin
      if (vx_q[i] < mnx) mnx = vx_q[i];
      if (vx_q[i] > mxx) mxx = vx_q[i];
      if (vy_q[i] < mny) mny = vy_q[i];
      if (vy_q[i] > mxy) mxy = vy_q[i];
    end
  end

  // floor division
  logic signed [31:0] dsel;
  logic [31:0]        dmag;
  div_res_t           div_res;
  logic               rnz;
  logic signed [33:0] qext, fq_d;
  logic [31:0]        fr_d;

  always_comb begin
    case (dix_q)
      2'd0:    dsel = bxl_q;
      2'd1:    dsel = bxh_q;
      2'd2:    dsel = byl_q;
      default: dsel = byh_q;
    endcase
  end

  assign dmag = dsel[31] ? (~dsel + 32'd1) : dsel;

  qfg_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .go_i  (div_go),
    .num_i (dmag),
    .den_i (size_q),
    .res_o (div_res)
  );

  assign rnz  = |div_res.rem;
  assign qext = {2'b00, div_res.quo};
  assign fq_d = dsel[31] ? -(qext + 34'(rnz)) : qext;
  assign fr_d = dsel[31] ? (rnz ? (size_q - div_res.rem) : '0) : div_res.rem;

  // window
  logic signed [33:0] kx0_w, kx1_w, ky0_w, ky1_w;
  logic [33:0]        cols_w, rows_w;
  logic [2*CW-1:0]    area_w;
  logic               too_big;
  logic signed [35:0] cxb_w, cyb_w;

  assign kx0_w  = fq_q[0] - 34'sd1;
  assign kx1_w  = fq_q[1] + 34'sd1;
  assign ky0_w  = fq_q[2] - 34'sd1;
  assign ky1_w  = fq_q[3] + 34'sd1;
  assign cols_w = 34'(kx1_w - kx0_w + 34'sd1);
  assign rows_w = 34'(ky1_w - ky0_w + 34'sd1);
  assign area_w = cols_w[CW-1:0] * rows_w[CW-1:0];
  assign too_big = (cols_w > 34'(MAX_SCAN_CELLS)) || (rows_w > 34'(MAX_SCAN_CELLS)) ||
                   (area_w > (2*CW)'(MAX_SCAN_CELLS));
  assign cxb_w = 36'(bxl_q) - 36'(fr0_q) - 36'(size_q);
  assign cyb_w = 36'(byl_q) - 36'(fr2_q) - 36'(size_q);

  // cell clipped to the bounding box
  logic signed [35:0] s36, bxl36, bxh36, byl36, byh36;
  logic signed [35:0] ux1, uy1, cx0, cx1, cy0, cy1;
  logic               nonempty;

  assign s36   = 36'(size_q);
  assign bxl36 = 36'(bxl_q);
  assign bxh36 = 36'(bxh_q);
  assign byl36 = 36'(byl_q);
  assign byh36 = 36'(byh_q);
  assign ux1   = cxb_q + s36;
  assign uy1   = cyb_q + s36;
  assign cx0   = (cxb_q < bxl36) ? bxl36 : cxb_q;
  assign cx1   = (ux1 > bxh36) ? bxh36 : ux1;
  assign cy0   = (cyb_q < byl36) ? byl36 : cyb_q;
  assign cy1   = (uy1 > byh36) ? byh36 : uy1;
  assign nonempty = (cx0 <= cx1) && (cy0 <= cy1);

  // edge a-b and box side c-d
  logic signed [31:0] ax, ay, bx, by, cx, cy, dx, dy;
  logic [1:0] k1;

  assign ax = vx_q[0];
  assign ay = vy_q[0];
  assign bx = vx_q[1];
  assign by = vy_q[1];
  assign k1 = k_q + 2'd1;

  always_comb begin
    case (k_q)
      2'd0:    begin cx = x0_q; cy = y0_q; end
      2'd1:    begin cx = x1_q; cy = y0_q; end
      2'd2:    begin cx = x1_q; cy = y1_q; end
      default: begin cx = x0_q; cy = y1_q; end
    endcase
    case (k1)
      2'd0:    begin dx = x0_q; dy = y0_q; end
      2'd1:    begin dx = x1_q; dy = y0_q; end
      2'd2:    begin dx = x1_q; dy = y1_q; end
      default: begin dx = x0_q; dy = y1_q; end
    endcase
  end

  logic signed [31:0] pax, pay, pbx, pby, pcx, pcy;
  ori_res_t           ori;

  always_comb begin
    if (state_q == S_XORI) begin
      pax = ax; pay = ay; pbx = bx; pby = by; pcx = x0_q; pcy = y0_q;
    end else begin
      case (j_q)
        2'd0:    begin pax = ax; pay = ay; pbx = bx; pby = by; pcx = cx; pcy = cy; end
        2'd1:    begin pax = ax; pay = ay; pbx = bx; pby = by; pcx = dx; pcy = dy; end
        2'd2:    begin pax = cx; pay = cy; pbx = dx; pby = dy; pcx = ax; pcy = ay; end
        default: begin pax = cx; pay = cy; pbx = dx; pby = dy; pcx = bx; pcy = by; end
      endcase
    end
  end

  qfg_orient u_orient (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .go_i  (ori_go),
    .ax_i  (pax),
    .ay_i  (pay),
    .bx_i  (pbx),
    .by_i  (pby),
    .cx_i  (pcx),
    .cy_i  (pcy),
    .res_o (ori)
  );

  logic vin, meet, crossing, toggle;

  assign vin = (ax >= x0_q) && (ax <= x1_q) && (ay >= y0_q) && (ay <= y1_q);

  assign meet =
    (((opos_q[0] != opos_q[1]) || (ozero_q[0] != ozero_q[1])) &&
     ((opos_q[2] != opos_q[3]) || (ozero_q[2] != ozero_q[3]))) ||
    (ozero_q[0] && in_span(ax, ay, bx, by, cx, cy)) ||
    (ozero_q[1] && in_span(ax, ay, bx, by, dx, dy)) ||
    (ozero_q[2] && in_span(cx, cy, dx, dy, ax, ay)) ||
    (ozero_q[3] && in_span(cx, cy, dx, dy, bx, by));

  assign crossing = (ay > y0_q) != (by > y0_q);
  assign toggle   = (by > ay) ? ori.pos : (!ori.pos && !ori.zero);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = (size_q == '0) ? S_OVR : S_BBOX;
      S_BBOX: state_d = S_DIV;
      S_DIV:  if (div_res.done && dix_q == 2'd3) state_d = S_WIN;
      S_WIN:  state_d = too_big ? S_OVR : S_CELL;
      S_CELL: state_d = nonempty ? S_VTX : S_NEXT;
      S_VTX:  state_d = vin ? S_HIT : S_ORI;
      S_ORI:  if (ori.done && j_q == 2'd3) state_d = S_SEG;
      S_SEG: begin
        if (meet) state_d = S_HIT;
        else if (k_q != 2'd3) state_d = S_ORI;
        else state_d = (ei_q == 2'd3) ? S_XCHK : S_VTX;
      end
      S_XCHK: begin
        if (crossing) state_d = S_XORI;
        else if (ei_q == 2'd3) state_d = S_XDEC;
      end
      S_XORI: if (ori.done) state_d = (ei_q == 2'd3) ? S_XDEC : S_XCHK;
      S_XDEC: state_d = inside_q ? S_HIT : S_NEXT;
      S_HIT:  if (!pend_q || slot_free) state_d = S_NEXT;
      S_NEXT: state_d = (ky_q == ky1_q && kx_q == kx1_q) ? S_FIN : S_CELL;
      S_FIN:  if (slot_free) state_d = S_IDLE;
      S_OVR:  if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    div_go    = 1'b0;
    ori_go    = 1'b0;
    push      = 1'b0;
    push_x    = pend_x_q;
    push_y    = pend_y_q;
    push_st   = STATUS_CELL;
    push_last = 1'b0;
    unique case (state_q)
      S_IDLE: in_ready = 1'b1;
      S_DIV:  div_go = 1'b1;
      S_ORI, S_XORI: ori_go = 1'b1;
      S_HIT:  push = pend_q && slot_free;
      S_FIN: begin
        push      = slot_free;
        push_last = 1'b1;
        if (!pend_q) begin
          push_x  = '0;
          push_y  = '0;
          push_st = STATUS_OVER;
        end
      end
      S_OVR: begin
        push      = slot_free;
        push_x    = '0;
        push_y    = '0;
        push_st   = STATUS_OVER;
        push_last = 1'b1;
      end
      default: ;
    endcase
  end

  assign in_acc    = item_i.valid && in_ready;
  assign slot_free = !ov_q || result_o.ready;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      size_q   <= CELL_SIZE_RESET;
      dix_q    <= '0;
      ei_q     <= '0;
      k_q      <= '0;
      j_q      <= '0;
      inside_q <= 1'b0;
      pend_q   <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) size_q <= cfg_i.data;
      if (push) ov_q <= 1'b1;
      else if (result_o.ready) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_acc) pend_q <= 1'b0;
        S_BBOX: dix_q <= '0;
        S_DIV:  if (div_res.done) dix_q <= dix_q + 2'd1;
        S_CELL: ei_q <= '0;
        S_VTX: begin
          k_q <= '0;
          j_q <= '0;
        end
        S_ORI:  if (ori.done) j_q <= j_q + 2'd1;
        S_SEG: begin
          if (!meet) begin
            if (k_q != 2'd3) k_q <= k_q + 2'd1;
            else ei_q <= ei_q + 2'd1;
            inside_q <= 1'b0;
          end
        end
        S_XCHK: if (!crossing) ei_q <= ei_q + 2'd1;
        S_XORI: begin
          if (ori.done) begin
            ei_q <= ei_q + 2'd1;
            if (toggle) inside_q <= !inside_q;
          end
        end
        S_HIT:  pend_q <= 1'b1;
        S_FIN:  if (slot_free) pend_q <= 1'b0;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (push) begin
      ox_q    <= push_x;
      oy_q    <= push_y;
      ost_q   <= push_st;
      olast_q <= push_last;
    end
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          vx_q[0] <= item_i.data.v0_x;
          vy_q[0] <= item_i.data.v0_y;
          vx_q[1] <= item_i.data.v1_x;
          vy_q[1] <= item_i.data.v1_y;
          vx_q[2] <= item_i.data.v2_x;
          vy_q[2] <= item_i.data.v2_y;
          vx_q[3] <= item_i.data.v3_x;
          vy_q[3] <= item_i.data.v3_y;
        end
      end
      S_BBOX: begin
        bxl_q <= mnx;
        bxh_q <= mxx;
        byl_q <= mny;
        byh_q <= mxy;
      end
      S_DIV: begin
        if (div_res.done) begin
          fq_q[dix_q] <= fq_d;
          if (dix_q == 2'd0) fr0_q <= fr_d;
          if (dix_q == 2'd2) fr2_q <= fr_d;
        end
      end
      S_WIN: begin
        kx_q   <= kx0_w;
        kx1_q  <= kx1_w;
        ky_q   <= ky0_w;
        ky0_q  <= ky0_w;
        ky1_q  <= ky1_w;
        cxb_q  <= cxb_w;
        cyb_q  <= cyb_w;
        cyb0_q <= cyb_w;
      end
      S_CELL: begin
        x0_q <= cx0[31:0];
        x1_q <= cx1[31:0];
        y0_q <= cy0[31:0];
        y1_q <= cy1[31:0];
      end
      S_ORI: begin
        if (ori.done) begin
          opos_q[j_q]  <= ori.pos;
          ozero_q[j_q] <= ori.zero;
        end
      end
      S_SEG, S_XCHK, S_XORI: begin
        if ((state_q == S_SEG && !meet && k_q == 2'd3) ||
            (state_q == S_XCHK && !crossing) || (state_q == S_XORI && ori.done)) begin
          vx_q[0] <= vx_q[1];
          vx_q[1] <= vx_q[2];
          vx_q[2] <= vx_q[3];
          vx_q[3] <= vx_q[0];
          vy_q[0] <= vy_q[1];
          vy_q[1] <= vy_q[2];
          vy_q[2] <= vy_q[3];
          vy_q[3] <= vy_q[0];
        end
      end
      S_HIT: begin
        if (!pend_q || slot_free) begin
          pend_x_q <= kx_q[31:0];
          pend_y_q <= ky_q[31:0];
        end
      end
      S_NEXT: begin
        if (ky_q == ky1_q) begin
          ky_q  <= ky0_q;
          cyb_q <= cyb0_q;
          kx_q  <= kx_q + 34'sd1;
          cxb_q <= cxb_q + s36;
        end else begin
          ky_q  <= ky_q + 34'sd1;
          cyb_q <= cyb_q + s36;
        end
      end
      default: ;
    endcase
  end

  assign cfg_i.ready          = 1'b1;
  assign item_i.ready         = in_ready;
  assign result_o.valid       = ov_q;
  assign result_o.data.cell_x = ox_q;
  assign result_o.data.cell_y = oy_q;
  assign result_o.data.status = ost_q;
  assign result_o.data.last   = olast_q;
endmodule

[rtl/qfg_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfg_div
// Restoring unsigned 32 by 32 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qfg_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  logic [31:0]      num_i,
  input  logic [31:0]      den_i,
  output qfg_pkg::div_res_t res_o
);
  import qfg_pkg::*;

  logic [5:0]  cnt_q;
  logic [31:0] acc_q;
  logic [32:0] rem_q;
  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_q[31:0], acc_q[31]};
  assign ge     = rem_sh >= {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (!go_i || cnt_q == 6'd33) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i && cnt_q == 6'd0) begin
      acc_q <= num_i;
      rem_q <= '0;
    end else if (go_i && cnt_q != 6'd33) begin
      acc_q <= {acc_q[30:0], ge};
      rem_q <= ge ? (rem_sh - {1'b0, den_i}) : rem_sh;
    end
  end

  assign res_o.done = go_i && (cnt_q == 6'd33);
  assign res_o.quo  = acc_q;
  assign res_o.rem  = rem_q[31:0];
endmodule

[rtl/qfg_orient.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfg_orient
// Exact orientation sign of three points with one shared multiplier.
// ----------------------------------------------------------------------------
module qfg_orient (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  logic signed [31:0] ax_i,
  input  logic signed [31:0] ay_i,
  input  logic signed [31:0] bx_i,
  input  logic signed [31:0] by_i,
  input  logic signed [31:0] cx_i,
  input  logic signed [31:0] cy_i,
  output qfg_pkg::ori_res_t  res_o
);
  import qfg_pkg::*;

  logic [1:0]         phase_q;
  logic signed [32:0] dbx, dby, dcx, dcy;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [65:0] p_q, q_q;

  assign dbx = 33'(bx_i) - 33'(ax_i);
  assign dby = 33'(by_i) - 33'(ay_i);
  assign dcx = 33'(cx_i) - 33'(ax_i);
  assign dcy = 33'(cy_i) - 33'(ay_i);

  assign mul_a = (phase_q == 2'd0) ? dbx : dby;
  assign mul_b = (phase_q == 2'd0) ? dcy : dcx;
  assign prod  = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (!go_i || phase_q == 2'd2) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == 2'd0) begin
      p_q <= prod;
    end
    if (phase_q == 2'd1) begin
      q_q <= prod;
    end
  end

  assign res_o.done = go_i && (phase_q == 2'd2);
  assign res_o.pos  = p_q > q_q;
  assign res_o.zero = p_q == q_q;
endmodule

[rtl/qfg_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfg_checker
// Port-level checks of the quad footprint grid cell scanner.
// ----------------------------------------------------------------------------
module qfg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] cell_x_i,
  input logic [31:0] cell_y_i,
  input logic        status_i,
  input logic        last_i
);
  import qfg_pkg::*;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cell_x_i) &&
    $stable(cell_y_i) && $stable(status_i) && $stable(last_i))
    else $error("stalled result changed");

  // over-status result is last and has zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STATUS_OVER |-> last_i && cell_x_i == '0 && cell_y_i == '0)
    else $error("bad oversize result");

  // one item in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item taken while busy");

  // no new item before the last result of the current one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_i |-> !in_ready_i)
    else $error("ready before last result");
endmodule

bind quad_footprint_grid_cells_core qfg_checker u_qfg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (item_i.valid),
  .in_ready_i (item_i.ready),
  .out_valid_i(result_o.valid),
  .out_ready_i(result_o.ready),
  .cell_x_i   (result_o.data.cell_x),
  .cell_y_i   (result_o.data.cell_y),
  .status_i   (result_o.data.status),
  .last_i     (result_o.data.last)
);

[verif/quad_footprint_grid_cells_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_footprint_grid_cells_core_tb
// Self-checking bench for the quad footprint grid cell scanner. Quads are
// driven on the item channel with random gaps, the occupied cells are
// predicted with exact wide-integer geometry and compared in order with the
// result channel, across several cell sizes written between phases.
// ----------------------------------------------------------------------------
module quad_footprint_grid_cells_core_tb;
  import qfg_pkg::*;

  typedef logic signed [71:0] wide_t;

  localparam int  MAX_CELLS   = 64;
  localparam int  DRAIN_WAIT  = 400;
  localparam longint CYCLE_LIMIT = 64'd60000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  qfg_chan_if #(.payload_t(cfg_word_t))  cfg_if ();
  qfg_chan_if #(.payload_t(quad_item_t)) quad_if ();
  qfg_chan_if #(.payload_t(cell_item_t)) cell_if ();

  quad_footprint_grid_cells_core #(.MAX_SCAN_CELLS(MAX_CELLS)) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if.sink),
    .item_i   (quad_if.sink),
    .result_o (cell_if.source)
  );

  always #5 clk_i = ~clk_i;

  quad_item_t quad_pending[$];
  cell_item_t cell_expected[$];
  logic [31:0] size_model = CELL_SIZE_RESET;
  logic quad_fire = 1'b0;
  logic quiet = 1'b0;
  int   errors = 0;
  longint cycles = 0;

  function automatic longint floor_by(longint v, longint s);
    if (v >= 0) return v / s;
    return -((-v + s - 1) / s);
  endfunction

  function automatic int orient(longint ax, longint ay, longint bx, longint by,
                                longint cx, longint cy);
    wide_t p;
    p = wide_t'(bx - ax) * wide_t'(cy - ay) - wide_t'(by - ay) * wide_t'(cx - ax);
    return (p > 0) ? 1 : ((p < 0) ? -1 : 0);
  endfunction

  function automatic bit on_span(longint ax, longint ay, longint bx, longint by,
                                 longint px, longint py);
    return px >= ((ax < bx) ? ax : bx) && px <= ((ax < bx) ? bx : ax) &&
           py >= ((ay < by) ? ay : by) && py <= ((ay < by) ? by : ay);
  endfunction

  function automatic bit segs_touch(longint ax, longint ay, longint bx, longint by,
                                    longint cx, longint cy, longint dx, longint dy);
    int o1, o2, o3, o4;
    o1 = orient(ax, ay, bx, by, cx, cy);
    o2 = orient(ax, ay, bx, by, dx, dy);
    o3 = orient(cx, cy, dx, dy, ax, ay);
    o4 = orient(cx, cy, dx, dy, bx, by);
    if (o1 != o2 && o3 != o4) return 1'b1;
    if (o1 == 0 && on_span(ax, ay, bx, by, cx, cy)) return 1'b1;
    if (o2 == 0 && on_span(ax, ay, bx, by, dx, dy)) return 1'b1;
    if (o3 == 0 && on_span(cx, cy, dx, dy, ax, ay)) return 1'b1;
    if (o4 == 0 && on_span(cx, cy, dx, dy, bx, by)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit quad_hits_box(longint vx[4], longint vy[4],
                                       longint x0, longint y0, longint x1, longint y1);
    bit odd;
    int j, o;
    odd = 1'b0;
    for (int i = 0; i < 4; i++) begin
      j = (i + 1) % 4;
      if (vx[i] >= x0 && vx[i] <= x1 && vy[i] >= y0 && vy[i] <= y1) return 1'b1;
      if (segs_touch(vx[i], vy[i], vx[j], vy[j], x0, y0, x1, y0) ||
          segs_touch(vx[i], vy[i], vx[j], vy[j], x1, y0, x1, y1) ||
          segs_touch(vx[i], vy[i], vx[j], vy[j], x1, y1, x0, y1) ||
          segs_touch(vx[i], vy[i], vx[j], vy[j], x0, y1, x0, y0)) return 1'b1;
    end
    // even-odd test of the box corner
    for (int i = 0; i < 4; i++) begin
      j = (i + 1) % 4;
      if ((vy[i] > y0) != (vy[j] > y0)) begin
        o = orient(vx[i], vy[i], vx[j], vy[j], x0, y0);
        if ((vy[j] > vy[i]) ? (o > 0) : (o < 0)) odd = ~odd;
      end
    end
    return odd;
  endfunction

  task automatic predict_cells(quad_item_t q);
    longint vx[4], vy[4];
    longint s, bx0, bx1, by0, by1, kx0, kx1, ky0, ky1, x0, x1, y0, y1, cols, rows;
    cell_item_t c;
    int n;
    vx[0] = q.v0_x; vy[0] = q.v0_y; vx[1] = q.v1_x; vy[1] = q.v1_y;
    vx[2] = q.v2_x; vy[2] = q.v2_y; vx[3] = q.v3_x; vy[3] = q.v3_y;
    s = longint'(size_model);
    n = 0;
    c = '0;
    if (s != 0) begin
      bx0 = vx[0]; bx1 = vx[0]; by0 = vy[0]; by1 = vy[0];
      for (int i = 1; i < 4; i++) begin
        if (vx[i] < bx0) bx0 = vx[i];
        if (vx[i] > bx1) bx1 = vx[i];
        if (vy[i] < by0) by0 = vy[i];
        if (vy[i] > by1) by1 = vy[i];
      end
      kx0 = floor_by(bx0, s) - 1; kx1 = floor_by(bx1, s) + 1;
      ky0 = floor_by(by0, s) - 1; ky1 = floor_by(by1, s) + 1;
      cols = kx1 - kx0 + 1;
      rows = ky1 - ky0 + 1;
      if (cols <= MAX_CELLS && rows <= MAX_CELLS && cols * rows <= MAX_CELLS) begin
        for (longint kx = kx0; kx <= kx1; kx++) begin
          for (longint ky = ky0; ky <= ky1; ky++) begin
            x0 = kx * s; y0 = ky * s; x1 = x0 + s; y1 = y0 + s;
            if (x0 < bx0) x0 = bx0;
            if (x1 > bx1) x1 = bx1;
            if (y0 < by0) y0 = by0;
            if (y1 > by1) y1 = by1;
            if (x0 <= x1 && y0 <= y1 && n < MAX_CELLS &&
                quad_hits_box(vx, vy, x0, y0, x1, y1)) begin
              c.cell_x = kx[31:0];
              c.cell_y = ky[31:0];
              c.status = STATUS_CELL;
              c.last   = 1'b0;
              cell_expected = {cell_expected, c};
              n++;
            end
          end
        end
      end
    end
    if (n == 0) begin
      c = '0;
      c.status = STATUS_OVER;
      c.last   = 1'b1;
      cell_expected = {cell_expected, c};
    end else begin
      cell_expected[cell_expected.size() - 1].last = 1'b1;
    end
  endtask

  // driver
  always @(negedge clk_i) begin
    logic       v_next;
    quad_item_t d_next;
    if (rst_ni) begin
      v_next = quad_if.valid;
      d_next = quad_if.data;
      if (!quad_if.valid || quad_fire) begin
        v_next = 1'b0;
        if (quad_pending.size() != 0 && (quiet || $urandom_range(99) >= 26)) begin
          v_next = 1'b1;
          d_next = quad_pending.pop_front();
        end
      end
      quad_if.valid <= v_next;
      quad_if.data  <= d_next;
      cell_if.ready <= quiet || ($urandom_range(99) >= 26);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cell_item_t want;
    cycles <= cycles + 1;
    quad_fire <= quad_if.valid && quad_if.ready;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) size_model = cfg_if.data;
      if (quad_if.valid && quad_if.ready) predict_cells(quad_if.data);
      if (cell_if.valid && cell_if.ready) begin
        if (cell_expected.size() == 0) begin
          $display("%0t unexpected result actual %p", $time, cell_if.data);
          errors++;
        end else begin
          want = cell_expected.pop_front();
          if (cell_if.data.cell_x !== want.cell_x)
            $display("%0t cell_x expected %0d actual %0d", $time, want.cell_x,
                     cell_if.data.cell_x);
          if (cell_if.data.cell_y !== want.cell_y)
            $display("%0t cell_y expected %0d actual %0d", $time, want.cell_y,
                     cell_if.data.cell_y);
          if (cell_if.data.status !== want.status)
            $display("%0t status expected %0b actual %0b", $time, want.status,
                     cell_if.data.status);
          if (cell_if.data.last !== want.last)
            $display("%0t last expected %0b actual %0b", $time, want.last,
                     cell_if.data.last);
          if (cell_if.data !== want) errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic quad_item_t random_quad(logic [31:0] s);
    quad_item_t q;
    logic [255:0] raw;
    longint span, cx, cy;
    q = '0;
    if ($urandom_range(99) < 20) begin
      for (int i = 0; i < 8; i++) raw[i*32 +: 32] = $urandom;
      q = raw;
    end else begin
      span = longint'(s) * $urandom_range(1, 5) / 2;
      if (span > 64'sd4294967295) span = 64'sd4294967295;
      cx = longint'($signed($urandom));
      cy = longint'($signed($urandom));
      q.v0_x = clamp32(cx + longint'($urandom) % (span + 1) - span / 2);
      q.v0_y = clamp32(cy + longint'($urandom) % (span + 1) - span / 2);
      q.v1_x = clamp32(cx + longint'($urandom) % (span + 1) - span / 2);
      q.v1_y = clamp32(cy + longint'($urandom) % (span + 1) - span / 2);
      q.v2_x = clamp32(cx + longint'($urandom) % (span + 1) - span / 2);
      q.v2_y = clamp32(cy + longint'($urandom) % (span + 1) - span / 2);
      q.v3_x = clamp32(cx + longint'($urandom) % (span + 1) - span / 2);
      q.v3_y = clamp32(cy + longint'($urandom) % (span + 1) - span / 2);
    end
    return q;
  endfunction

  function automatic quad_item_t make_quad(int ax, int ay, int bx, int by,
                                           int cx, int cy, int dx, int dy);
    quad_item_t q;
    q.v0_x = ax; q.v0_y = ay; q.v1_x = bx; q.v1_y = by;
    q.v2_x = cx; q.v2_y = cy; q.v3_x = dx; q.v3_y = dy;
    return q;
  endfunction

  task automatic queue_quad(quad_item_t q);
    quad_pending = {quad_pending, q};
  endtask

  task automatic wait_drained();
    while (quad_pending.size() != 0 || quad_if.valid || cell_expected.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_size(logic [31:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  localparam int ONE = 65536;
  localparam int MINV = 32'sh80000000;
  localparam int MAXV = 32'sh7fffffff;

  initial begin
    logic [31:0] sizes[5];
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    quad_if.valid = 1'b0;
    quad_if.data  = '0;
    cell_if.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset cell size
    queue_quad(make_quad(0, 0, 0, 0, 0, 0, 0, 0));
    queue_quad(make_quad(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV));
    queue_quad(make_quad(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
    queue_quad(make_quad(MINV, MINV, MAXV, MINV, MAXV, MAXV, MINV, MAXV));
    queue_quad(make_quad(0, 0, ONE, 0, ONE, ONE, 0, ONE));
    queue_quad(make_quad(-ONE, -ONE, 2*ONE, -ONE, 2*ONE, 2*ONE, -ONE, 2*ONE));
    queue_quad(make_quad(0, 0, 3*ONE, 3*ONE, 3*ONE, 0, 0, 3*ONE));
    queue_quad(make_quad(0, 0, ONE, ONE, 2*ONE, 2*ONE, 3*ONE, 3*ONE));
    queue_quad(make_quad(ONE/2, ONE/2, ONE/2, ONE/2, 5*ONE/2, ONE/2,
                         ONE/2, 5*ONE/2));
    queue_quad(make_quad(-ONE/3, 0, 0, 3*ONE, 3*ONE, 3*ONE+1, 3*ONE, -1));
    queue_quad(make_quad(0, 3*ONE, 3*ONE, 0, 0, 0, 3*ONE, 3*ONE));
    queue_quad(make_quad(-5*ONE, -2*ONE, 4*ONE, -2*ONE, 4*ONE, -1, -5*ONE, -1));
    queue_quad(make_quad(MAXV, 0, MAXV-1, ONE, MAXV-ONE, 0, MAXV, -ONE));
    queue_quad(make_quad(0, 0, 7*ONE, 0, 7*ONE, 7*ONE, 0, 7*ONE));
    wait_drained();

    sizes[0] = 32'd1;
    sizes[1] = 32'hffffffff;
    sizes[2] = $urandom_range(32'd4096, 32'd1048576);
    sizes[3] = $urandom;
    sizes[4] = CELL_SIZE_RESET;
    for (int p = 0; p < 5; p++) begin
      write_size(sizes[p]);
      if (p == 0) begin
        queue_quad(make_quad(MINV, MINV, MINV+1, MINV, MINV+1, MINV+1,
                             MINV, MINV+1));
        queue_quad(make_quad(MAXV, MAXV, MAXV-1, MAXV, MAXV, MAXV-2,
                             MAXV-1, MAXV-1));
      end
      for (int i = 0; i < 72; i++) begin
        queue_quad(random_quad(sizes[p]));
        if (p == 2 && i == 10) quiet = 1'b1;
        if (p == 2 && i == 60) begin
          while (quad_pending.size() != 0) @(posedge clk_i);
          quiet = 1'b0;
        end
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/qfg_pkg.sv
rtl/qfg_chan_if.sv
rtl/qfg_div.sv
rtl/qfg_orient.sv
rtl/quad_footprint_grid_cells_core.sv
rtl/qfg_checker.sv
verif/quad_footprint_grid_cells_core_tb.sv
